// ===== rtl/core/bfd_session_seq_ack_checker_unit_macros.svh =====
// Assertion macros for the session sequence/acknowledgement checker.
// Included by the RTL files that carry concurrent assertions.
`ifndef BFD_SESSION_SEQ_ACK_CHECKER_UNIT_MACROS_SVH
`define BFD_SESSION_SEQ_ACK_CHECKER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define BFD_SC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bfd_sc assertion failed");

`define BFD_SC_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("bfd_sc assertion failed");

`else

`define BFD_SC_ASSERT(label, clk, rst_n, prop)

`define BFD_SC_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ===== rtl/core/bfd_sc_pkg.sv =====
// Types and constants shared by the session sequence/acknowledgement checker.
// No dependencies.
package bfd_sc_pkg;

  localparam logic [15:0] ResetAck = 16'hFFFF;

  typedef enum logic [1:0] {
    OutNone   = 2'd0,
    OutReset  = 2'd1,
    OutAccept = 2'd2,
    OutReject = 2'd3
  } outcome_e;

  typedef struct packed {
    logic        session_hit;
    logic [6:0]  session_index;
    logic [15:0] peer_seq;
    logic [15:0] peer_ack;
    logic [63:0] now_ns;
  } probe_t;

  typedef struct packed {
    outcome_e outcome;
    logic     drop;
  } result_t;

  typedef struct packed {
    logic [15:0] seq;
    logic [15:0] ack;
  } tag_t;

  typedef struct packed {
    tag_t        tag;
    logic [63:0] stamp;
  } entry_t;

  typedef struct packed {
    result_t res;
    logic    wr_en;
    entry_t  entry;
  } decision_t;

endpackage

// ===== rtl/core/bfd_sc_if.sv =====
// Valid/ready channel interfaces for probes in and results out.
// Depends on bfd_sc_pkg.
interface bfd_sc_probe_if import bfd_sc_pkg::*; ();
  logic   valid;
  logic   ready;
  probe_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface bfd_sc_result_if import bfd_sc_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/bfd_sc_table.sv =====
// Per-session state memory with one read and one write port and a clear sweep.
// Depends on bfd_sc_pkg.
module bfd_sc_table import bfd_sc_pkg::*; #(
  parameter int unsigned SESSIONS = 128,
  localparam int unsigned IdxW = (SESSIONS > 1) ? $clog2(SESSIONS) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rd_en_i,
  input  logic [IdxW-1:0] rd_addr_i,
  output tag_t            rd_tag_o,
  input  logic            wr_en_i,
  input  logic [IdxW-1:0] wr_addr_i,
  input  entry_t          wr_entry_i,
  output logic            busy_o
);

  tag_t        tag_mem [SESSIONS];
  logic [63:0] stamp_mem [SESSIONS];
  tag_t        rd_tag_q;

  logic            busy_q, busy_d;
  logic [IdxW-1:0] clr_addr_q, clr_addr_d;

  logic            mem_we;
  logic [IdxW-1:0] mem_addr;
  entry_t          mem_entry;

  always_comb begin
    busy_d     = busy_q;
    clr_addr_d = clr_addr_q;
    if (busy_q) begin
      if (clr_addr_q == IdxW'(SESSIONS - 1)) begin
        busy_d = 1'b0;
      end else begin
        clr_addr_d = clr_addr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      busy_q     <= busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  assign mem_we    = busy_q || wr_en_i;
  assign mem_addr  = busy_q ? clr_addr_q : wr_addr_i;
  assign mem_entry = busy_q ? entry_t'('0) : wr_entry_i;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tag_mem[mem_addr]   <= mem_entry.tag;
      stamp_mem[mem_addr] <= mem_entry.stamp;
    end
    if (rd_en_i) begin
      rd_tag_q <= tag_mem[rd_addr_i];
    end
  end

  assign rd_tag_o = rd_tag_q;
  assign busy_o   = busy_q;

endmodule

// ===== rtl/core/bfd_sc_check.sv =====
// Acknowledgement advance check and entry update for one probe.
// Depends on bfd_sc_pkg.
module bfd_sc_check import bfd_sc_pkg::*; (
  input  logic      hit_i,
  input  probe_t    probe_i,
  input  tag_t      tag_i,
  output decision_t dec_o
);

  logic advances;

  always_comb begin
    if (tag_i.seq >= tag_i.ack) begin
      advances = probe_i.peer_ack > tag_i.ack;
    end else begin
      advances = (probe_i.peer_ack > tag_i.ack) || (probe_i.peer_ack <= tag_i.seq);
    end
  end

  always_comb begin
    dec_o.res.outcome     = OutNone;
    dec_o.res.drop        = 1'b0;
    dec_o.wr_en           = 1'b0;
    dec_o.entry.tag.seq   = probe_i.peer_seq;
    dec_o.entry.tag.ack   = probe_i.peer_ack;
    dec_o.entry.stamp     = probe_i.now_ns;
    if (hit_i) begin
      if ((probe_i.peer_seq == 16'd0) && (probe_i.peer_ack == 16'd0)) begin
        dec_o.res.outcome   = OutReset;
        dec_o.wr_en         = 1'b1;
        dec_o.entry.tag.seq = 16'd0;
        dec_o.entry.tag.ack = ResetAck;
        dec_o.entry.stamp   = 64'd0;
      end else if (advances) begin
        dec_o.res.outcome = OutAccept;
        dec_o.wr_en       = 1'b1;
      end else begin
        dec_o.res.outcome = OutReject;
        dec_o.res.drop    = 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/bfd_session_seq_ack_checker_unit.sv =====
// Top level of the session sequence/acknowledgement checker.
// Depends on bfd_sc_pkg, bfd_sc_if, bfd_sc_table, bfd_sc_check and the macro header.
//
//   channel    dir  transaction
//   probe_i    in   one received probe: hit, index, seq, ack, arrival time
//   result_o   out  one outcome code and drop flag per probe
//
// Accepted probes pass the read stage, then the output register. One probe per cycle
// is sustained while result_o.ready is high, set by the single table read port with
// the last write forwarded. After reset a clear sweep writes all SESSIONS entries,
// one per cycle, with probe_i.ready low throughout.
// A stalled result holds the output register and backs up into the read stage.
`include "bfd_session_seq_ack_checker_unit_macros.svh"

module bfd_session_seq_ack_checker_unit import bfd_sc_pkg::*; #(
  parameter int unsigned SESSIONS = 128
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  bfd_sc_probe_if.sink     probe_i,
  bfd_sc_result_if.source  result_o
);

  localparam int unsigned IdxW = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;

  logic            clr_busy;
  logic            accept;
  logic            s1_adv;
  logic [31:0]     idx_wide;
  logic            in_hit;

  logic            s1_valid_q;
  logic            s1_hit_q;
  logic [IdxW-1:0] s1_addr_q;
  probe_t          s1_probe_q;

  tag_t            rd_tag;
  tag_t            cur_tag;
  decision_t       dec;
  logic            wr_en;

  logic            fwd_valid_q;
  logic [IdxW-1:0] fwd_addr_q;
  tag_t            fwd_tag_q;

  logic            out_valid_q;
  result_t         out_q;

  assign idx_wide = 32'(probe_i.payload.session_index);
  assign in_hit   = probe_i.payload.session_hit && (idx_wide < 32'(SESSIONS));

  assign s1_adv        = s1_valid_q && (!out_valid_q || result_o.ready);
  assign probe_i.ready = !clr_busy && (!s1_valid_q || s1_adv);
  assign accept        = probe_i.valid && probe_i.ready;

  bfd_sc_table #(
    .SESSIONS (SESSIONS)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (accept),
    .rd_addr_i  (idx_wide[IdxW-1:0]),
    .rd_tag_o   (rd_tag),
    .wr_en_i    (wr_en),
    .wr_addr_i  (s1_addr_q),
    .wr_entry_i (dec.entry),
    .busy_o     (clr_busy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_hit_q   <= in_hit;
      s1_addr_q  <= idx_wide[IdxW-1:0];
      s1_probe_q <= probe_i.payload;
    end
  end

  // Forward the last write over a read that raced it.
  assign cur_tag = (fwd_valid_q && (fwd_addr_q == s1_addr_q)) ? fwd_tag_q : rd_tag;

  bfd_sc_check u_check (
    .hit_i   (s1_hit_q),
    .probe_i (s1_probe_q),
    .tag_i   (cur_tag),
    .dec_o   (dec)
  );

  assign wr_en = s1_adv && dec.wr_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else if (wr_en) begin
      fwd_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fwd_addr_q <= s1_addr_q;
      fwd_tag_q  <= dec.entry.tag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q <= dec.res;
    end
  end

  assign result_o.valid   = out_valid_q;
  assign result_o.payload = out_q;

  `BFD_SC_ASSERT(a_drop_iff_reject, clk_i, rst_ni,
    out_valid_q |-> (out_q.drop == (out_q.outcome == OutReject)))
  `BFD_SC_ASSERT(a_no_item_during_clear, clk_i, rst_ni, clr_busy |-> !s1_valid_q)
  `BFD_SC_ASSERT(a_write_needs_hit, clk_i, rst_ni, wr_en |-> s1_hit_q)
  `BFD_SC_ASSERT_ALWAYS(a_reset_idle, clk_i,
    $rose(rst_ni) |-> (clr_busy && !out_valid_q && !s1_valid_q))

endmodule
